// ===== design/qte_pkg.sv =====
// Shared constants, types and helper functions for the quaternion to Euler angle block.
// No dependencies; imported by every module of the block.
package qte_pkg;

    localparam int QUAT_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    // Raw component products and their rescaling to 30 fraction bits.
    localparam int PROD_W   = 2 * QUAT_BITS;
    localparam int PROD_SH  = 2 * (QUAT_BITS - 1) - 30;
    localparam int PROD_SHR = (PROD_SH >= 0) ? PROD_SH : 0;
    localparam int PROD_SHL = (PROD_SH < 0) ? -PROD_SH : 0;

    // Sums of two Q.30 products times two stay below 2^33 in magnitude.
    localparam int SUM_W = 35;

    // Square root: clamped argument is below 2^33, so 17 result digits.
    localparam int SQRT_IN_W  = 34;
    localparam int SQRT_W     = 35;
    localparam int SQRT_STEPS = 17;
    localparam int ROOT_W     = 17;

    // CORDIC datapath and angle widths.
    localparam int CORD_W    = 54;
    localparam int ARG_SHIFT = 16;
    localparam int ANG_W     = 28;
    localparam int OUT_W     = 30;

    // Register stages: input, products, sums, root, CORDIC setup and steps, output.
    localparam int PIPE_DEPTH = 3 + SQRT_STEPS + CORDIC_STEPS + 2;
    localparam int CLAMP_DLY  = SQRT_STEPS + CORDIC_STEPS + 1;

    typedef logic signed [QUAT_BITS-1:0] t_quat;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [ANG_W-1:0]     t_angle;
    typedef logic signed [OUT_W-1:0]     t_wide_angle;

    localparam t_sum   ONE_Q30     = t_sum'(64'sd1073741824);
    localparam t_angle PI_Q24      = t_angle'(32'sd52707179);
    localparam t_angle HALF_PI_Q24 = t_angle'(32'sd26353589);
    localparam int     ROLL_LIMIT  = 25736;
    localparam int     PITCH_LIMIT = 12868;

    // Bring a raw product to Q.30 (floor on right shifts) and widen to the sum width.
    function automatic t_sum prod_q30(input t_prod p);
        logic signed [63:0] e;
        e = 64'(p);
        e = (e >>> PROD_SHR) <<< PROD_SHL;
        return e[SUM_W-1:0];
    endfunction

    // Rounded arctangent of 2^-i in Q.24 radians.
    function automatic t_angle atan_entry(input int unsigned i);
        t_angle v;
        case (i)
            0:       v = t_angle'(32'sd13176795);
            1:       v = t_angle'(32'sd7778716);
            2:       v = t_angle'(32'sd4110060);
            3:       v = t_angle'(32'sd2086331);
            4:       v = t_angle'(32'sd1047214);
            5:       v = t_angle'(32'sd524117);
            6:       v = t_angle'(32'sd262123);
            7:       v = t_angle'(32'sd131069);
            8:       v = t_angle'(32'sd65536);
            9:       v = t_angle'(32'sd32768);
            10:      v = t_angle'(32'sd16384);
            11:      v = t_angle'(32'sd8192);
            12:      v = t_angle'(32'sd4096);
            13:      v = t_angle'(32'sd2048);
            14:      v = t_angle'(32'sd1024);
            15:      v = t_angle'(32'sd512);
            16:      v = t_angle'(32'sd256);
            17:      v = t_angle'(32'sd128);
            18:      v = t_angle'(32'sd64);
            19:      v = t_angle'(32'sd32);
            20:      v = t_angle'(32'sd16);
            21:      v = t_angle'(32'sd8);
            22:      v = t_angle'(32'sd4);
            23:      v = t_angle'(32'sd2);
            24:      v = t_angle'(32'sd1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/qte_sqrt.sv =====
// Pipelined floor square root, one result digit per register stage.
// Depends on qte_pkg.
module qte_sqrt import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQRT_IN_W-1:0] i_val,
    output logic [ROOT_W-1:0]    o_root
);

    logic [SQRT_W-1:0] r_n [SQRT_STEPS];
    logic [SQRT_W-1:0] r_r [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQRT_W-1:0] n_in;
        logic [SQRT_W-1:0] r_in;
        logic [SQRT_W-1:0] trial;

        if (k == 0) begin : g_first
            assign n_in = SQRT_W'(i_val);
            assign r_in = '0;
        end else begin : g_next
            assign n_in = r_n[k-1];
            assign r_in = r_r[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_in >= trial) begin
                    r_n[k] <= n_in - trial;
                    r_r[k] <= (r_in >> 1) + BIT;
                end else begin
                    r_n[k] <= n_in;
                    r_r[k] <= r_in >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== design/qte_cordic.sv =====
// Pipelined vectoring CORDIC that returns atan2(y, x) in Q.24 radians.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_sum   i_y,
    input  t_sum   i_x,
    output t_angle o_angle
);

    typedef logic signed [CORD_W-1:0] t_cw;

    t_cw    r_x    [CORDIC_STEPS+1];
    t_cw    r_y    [CORDIC_STEPS+1];
    t_angle r_z    [CORDIC_STEPS+1];
    logic   r_zero [CORDIC_STEPS+1];

    t_cw    n_x;
    t_cw    n_y;
    t_angle n_z;

    // Setup: fold the left half plane onto the right one and scale up.
    always_comb begin
        n_x = CORD_W'(i_x);
        n_y = CORD_W'(i_y);
        n_z = '0;
        if (i_x < 0) begin
            n_x = -n_x;
            n_y = -n_y;
            n_z = (i_y >= 0) ? PI_Q24 : -PI_Q24;
        end
        n_x = n_x <<< ARG_SHIFT;
        n_y = n_y <<< ARG_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam t_angle ATAN = atan_entry(i);
        t_cw dx;
        t_cw dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN;
                end
            end
        end
    end

    assign o_angle = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];

endmodule

// ===== design/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle converter (roll, pitch, yaw).
// Depends on qte_pkg, qte_sqrt and qte_cordic.
//
// Usage: the input channel carries one Q1.15 rotation quaternion per transaction
// (i_valid, o_stall, i_quat_w/x/y/z). The output channel returns one transaction
// per input with roll and yaw in Q3.13 and pitch in Q2.13 radians plus a flag that is set
// when a pitch root argument went negative and was clamped to zero
// (o_valid, i_stall, o_roll_angle, o_pitch_angle, o_yaw_angle, o_root_clamped).
// Throughput is one transaction per clock while no result is held on the output.
// The edge that accepts a quaternion loads the input register, and after it come
// one product stage, one sum stage, 17 stages of the pitch square root,
// one CORDIC setup stage, 16 CORDIC steps and the output rounding stage, at
// which its result first shows on the output register.
// Roll and yaw arguments ride in delay registers beside the root.
// The pipeline is one shift chain; it holds whenever a result waits on the
// output and the receiver stalls, and o_stall then tells the sender to hold.
// While the output is empty or being taken, the sender is never stalled.
// Synchronous reset clears the valid bits only, so no transaction is in
// flight afterwards; data registers come up with whatever they hold.
module quaternion_to_euler import qte_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_quat                  i_quat_w,
    input  t_quat                  i_quat_x,
    input  t_quat                  i_quat_y,
    input  t_quat                  i_quat_z,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [15:0]     o_roll_angle,
    output logic signed [14:0]     o_pitch_angle,
    output logic signed [15:0]     o_yaw_angle,
    output logic                   o_root_clamped
);

    // Round half up from Q.24 to Q3.13 and saturate symmetrically.
    function automatic logic signed [15:0] to_q13(input t_wide_angle a, input int limit);
        t_wide_angle r;
        t_wide_angle lim;
        r   = (a + t_wide_angle'(1024)) >>> 11;
        lim = t_wide_angle'(limit);
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r[15:0];
    endfunction

    logic en;
    logic [PIPE_DEPTH-1:0] r_valid;

    // The whole pipeline advances unless a finished result is being held.
    assign en      = !(r_valid[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_valid[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Stage 0: capture the quaternion.
    t_quat r_w, r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_quat_w;
            r_x <= i_quat_x;
            r_y <= i_quat_y;
            r_z <= i_quat_z;
        end
    end

    // Stage 1: the nine component products.
    t_prod r_wx, r_yz, r_xx, r_yy, r_zz, r_wy, r_xz, r_wz, r_xy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= PROD_W'(r_w) * PROD_W'(r_x);
            r_yz <= PROD_W'(r_y) * PROD_W'(r_z);
            r_xx <= PROD_W'(r_x) * PROD_W'(r_x);
            r_yy <= PROD_W'(r_y) * PROD_W'(r_y);
            r_zz <= PROD_W'(r_z) * PROD_W'(r_z);
            r_wy <= PROD_W'(r_w) * PROD_W'(r_y);
            r_xz <= PROD_W'(r_x) * PROD_W'(r_z);
            r_wz <= PROD_W'(r_w) * PROD_W'(r_z);
            r_xy <= PROD_W'(r_x) * PROD_W'(r_y);
        end
    end

    // Stage 2: arctangent arguments and the clamped root arguments.
    t_sum n_sr, n_cr, n_sy, n_cy, n_t, n_a, n_b;
    logic n_clamp;

    always_comb begin
        n_sr = (prod_q30(r_wx) + prod_q30(r_yz)) <<< 1;
        n_cr = ONE_Q30 - ((prod_q30(r_xx) + prod_q30(r_yy)) <<< 1);
        n_sy = (prod_q30(r_wz) + prod_q30(r_xy)) <<< 1;
        n_cy = ONE_Q30 - ((prod_q30(r_yy) + prod_q30(r_zz)) <<< 1);
        n_t  = (prod_q30(r_wy) - prod_q30(r_xz)) <<< 1;
        n_a  = ONE_Q30 + n_t;
        n_b  = ONE_Q30 - n_t;
        n_clamp = 1'b0;
        if (n_a < 0) begin
            n_a     = '0;
            n_clamp = 1'b1;
        end
        if (n_b < 0) begin
            n_b     = '0;
            n_clamp = 1'b1;
        end
    end

    t_sum r_sr, r_cr, r_sy, r_cy;
    logic [SQRT_IN_W-1:0] r_a, r_b;
    logic r_clamp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr    <= n_sr;
            r_cr    <= n_cr;
            r_sy    <= n_sy;
            r_cy    <= n_cy;
            r_a     <= n_a[SQRT_IN_W-1:0];
            r_b     <= n_b[SQRT_IN_W-1:0];
            r_clamp <= n_clamp;
        end
    end

    // Pitch roots; roll and yaw arguments wait beside them.
    logic [ROOT_W-1:0] root_a, root_b;

    qte_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_a),
        .o_root (root_a)
    );

    qte_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_b),
        .o_root (root_b)
    );

    t_sum r_sr_dly [SQRT_STEPS];
    t_sum r_cr_dly [SQRT_STEPS];
    t_sum r_sy_dly [SQRT_STEPS];
    t_sum r_cy_dly [SQRT_STEPS];
    logic [CLAMP_DLY-1:0] r_clamp_dly;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr_dly[0] <= r_sr;
            r_cr_dly[0] <= r_cr;
            r_sy_dly[0] <= r_sy;
            r_cy_dly[0] <= r_cy;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sr_dly[k] <= r_sr_dly[k-1];
                r_cr_dly[k] <= r_cr_dly[k-1];
                r_sy_dly[k] <= r_sy_dly[k-1];
                r_cy_dly[k] <= r_cy_dly[k-1];
            end
            r_clamp_dly <= {r_clamp_dly[CLAMP_DLY-2:0], r_clamp};
        end
    end

    // Three arctangent units.
    t_angle roll_z, pitch_z, yaw_z;

    qte_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sr_dly[SQRT_STEPS-1]),
        .i_x     (r_cr_dly[SQRT_STEPS-1]),
        .o_angle (roll_z)
    );

    qte_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (SUM_W'(root_a)),
        .i_x     (SUM_W'(root_b)),
        .o_angle (pitch_z)
    );

    qte_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sy_dly[SQRT_STEPS-1]),
        .i_x     (r_cy_dly[SQRT_STEPS-1]),
        .o_angle (yaw_z)
    );

    // Output stage: pitch is twice its arctangent less a quarter turn.
    t_wide_angle n_pitch_wide;
    logic signed [15:0] n_pitch16;

    assign n_pitch_wide = (OUT_W'(pitch_z) <<< 1) - OUT_W'(HALF_PI_Q24);
    assign n_pitch16    = to_q13(n_pitch_wide, PITCH_LIMIT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle   <= to_q13(OUT_W'(roll_z), ROLL_LIMIT);
            o_pitch_angle  <= n_pitch16[14:0];
            o_yaw_angle    <= to_q13(OUT_W'(yaw_z), ROLL_LIMIT);
            o_root_clamped <= r_clamp_dly[CLAMP_DLY-1];
        end
    end

`ifndef SYNTHESIS
    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_valid))
        else $error("pipeline moved while the output was held");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle >= -15'sd12868) && (o_pitch_angle <= 15'sd12868))
        else $error("pitch outside its saturation range");

    a_roll_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle >= -16'sd25736) && (o_roll_angle <= 16'sd25736)
                 && (o_yaw_angle >= -16'sd25736) && (o_yaw_angle <= 16'sd25736))
        else $error("roll or yaw outside its saturation range");
`endif

endmodule
